/* src/frustum_box_cull_test_assert.svh */
// ---------------------------------------------------------------------------
// frustum_box_cull_test assertion macros
// Shared concurrent assertion forms for the box cull pipeline.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_TEST_ASSERT_SVH
`define FRUSTUM_BOX_CULL_TEST_ASSERT_SVH

// same-cycle implication
`define FBCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define FBCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* src/fbct_pkg.sv */
// ---------------------------------------------------------------------------
// fbct_pkg
// Types and constants of the frustum box cull test.
// ---------------------------------------------------------------------------
package fbct_pkg;

  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NORM_W     = 16;
  localparam int OFF_W      = 16;
  localparam int FRAC_W     = 14;
  localparam int OFF_TERM_W = OFF_W + FRAC_W;
  localparam int NUM_AXES   = 3;

  // register packing: offset in the top field, then nz, ny, nx
  typedef struct packed {
    logic signed [OFF_W-1:0]  off;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

endpackage

/* src/fbct_axis_sort.sv */
// ---------------------------------------------------------------------------
// fbct_axis_sort
// Registers the lower and higher of the two box coordinates on one axis.
// ---------------------------------------------------------------------------
module fbct_axis_sort #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output logic signed [COORD_BITS-1:0] lo_o,
  output logic signed [COORD_BITS-1:0] hi_o
);

  logic signed [COORD_BITS-1:0] lo_r;
  logic signed [COORD_BITS-1:0] hi_r;
  logic                         swap;

  assign swap = (a_i > b_i);

  always_ff @(posedge clk) begin
    lo_r <= swap ? b_i : a_i;
    hi_r <= swap ? a_i : b_i;
  end

  assign lo_o = lo_r;
  assign hi_o = hi_r;

endmodule

/* src/fbct_plane_eval.sv */
// ---------------------------------------------------------------------------
// fbct_plane_eval
// Far-corner distance of a box against one plane: a product stage, then a
// sum and sign stage. Flags the plane when the distance is negative.
// ---------------------------------------------------------------------------
`include "frustum_box_cull_test_assert.svh"

module fbct_plane_eval #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbct_pkg::plane_t             plane_i,
  input  logic signed [COORD_BITS-1:0] lo_i [fbct_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] hi_i [fbct_pkg::NUM_AXES],
  output logic                         neg_o
);

  localparam int PW = COORD_BITS + fbct_pkg::NORM_W;
  localparam int SW = ((PW > fbct_pkg::OFF_TERM_W) ? PW : fbct_pkg::OFF_TERM_W) + 2;

  logic signed [fbct_pkg::NORM_W-1:0]     nrm [fbct_pkg::NUM_AXES];
  logic signed [PW-1:0]                   prod_nxt [fbct_pkg::NUM_AXES];
  logic signed [PW-1:0]                   prod_r [fbct_pkg::NUM_AXES];
  logic signed [fbct_pkg::OFF_TERM_W-1:0] off_term;
  logic signed [SW-1:0]                   sum_nxt;
  logic                                   neg_r;

  assign nrm[0] = plane_i.nx;
  assign nrm[1] = plane_i.ny;
  assign nrm[2] = plane_i.nz;

  // negative normal takes the low corner, otherwise the high one
  always_comb begin
    for (int k = 0; k < fbct_pkg::NUM_AXES; k++) begin
      prod_nxt[k] = PW'(nrm[k]) *
                    PW'(nrm[k][fbct_pkg::NORM_W-1] ? lo_i[k] : hi_i[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fbct_pkg::NUM_AXES; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
  end

  assign off_term = {plane_i.off, {fbct_pkg::FRAC_W{1'b0}}};
  assign sum_nxt  = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + SW'(off_term);

  always_ff @(posedge clk) begin
    neg_r <= sum_nxt[SW-1];
  end

  assign neg_o = neg_r;

  // an all-zero plane held over both stages never culls
  `FBCT_ASSERT_IMPL(a_zero_plane_keeps, clk, rst_n,
    $past(plane_i == '0) && $past(plane_i == '0, 2), !neg_r)

endmodule

/* src/frustum_box_cull_test.sv */
// ---------------------------------------------------------------------------
// frustum_box_cull_test
// Tests an axis-aligned box against the configured frustum planes.
// ---------------------------------------------------------------------------
// One box is taken in every clock cycle; busy is high only while rst_n is
// low. Each box gives one beat on out_valid/out_visible after it passes the
// axis sort, product, plane sum and result registers, in the order the boxes
// came in; the receiver cannot hold beats off.
// Planes are written through cfg_we/cfg_index/cfg_data and reset to zero,
// which never culls; write them only while no box is in flight.
// ---------------------------------------------------------------------------
`include "frustum_box_cull_test_assert.svh"

module frustum_box_cull_test #(
  parameter int NUM_PLANES = 6,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        in_box_min_x,
  input  logic signed [COORD_BITS-1:0]        in_box_min_y,
  input  logic signed [COORD_BITS-1:0]        in_box_min_z,
  input  logic signed [COORD_BITS-1:0]        in_box_max_x,
  input  logic signed [COORD_BITS-1:0]        in_box_max_y,
  input  logic signed [COORD_BITS-1:0]        in_box_max_z,
  output logic                                out_valid,
  output logic                                out_visible,
  input  logic                                cfg_we,
  input  logic [fbct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbct_pkg::CFG_DATA_W-1:0]     cfg_data
);

  fbct_pkg::plane_t             plane_r [fbct_pkg::NUM_REGS];
  logic signed [COORD_BITS-1:0] mn [fbct_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] mx [fbct_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] lo_s1 [fbct_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] hi_s1 [fbct_pkg::NUM_AXES];
  logic [NUM_PLANES-1:0]        cull_s3;
  logic                         in_beat;
  logic                         v_s1_r;
  logic                         v_s2_r;
  logic                         v_s3_r;
  logic                         out_valid_r;
  logic                         out_visible_r;

  assign busy    = !rst_n;
  assign in_beat = start && !busy;

  // plane registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < fbct_pkg::NUM_REGS; i++) begin
      if (!rst_n) begin
        plane_r[i] <= '0;
      end else if (cfg_we && (cfg_index == fbct_pkg::CFG_IDX_W'(i))) begin
        plane_r[i] <= fbct_pkg::plane_t'(cfg_data);
      end
    end
  end

  assign mn[0] = in_box_min_x;
  assign mn[1] = in_box_min_y;
  assign mn[2] = in_box_min_z;
  assign mx[0] = in_box_max_x;
  assign mx[1] = in_box_max_y;
  assign mx[2] = in_box_max_z;

  for (genvar k = 0; k < fbct_pkg::NUM_AXES; k++) begin : g_axis
    fbct_axis_sort #(
      .COORD_BITS (COORD_BITS)
    ) u_sort (
      .clk  (clk),
      .a_i  (mn[k]),
      .b_i  (mx[k]),
      .lo_o (lo_s1[k]),
      .hi_o (hi_s1[k])
    );
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    if (p < fbct_pkg::NUM_REGS) begin : g_live
      fbct_plane_eval #(
        .COORD_BITS (COORD_BITS)
      ) u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .plane_i (plane_r[p]),
        .lo_i    (lo_s1),
        .hi_i    (hi_s1),
        .neg_o   (cull_s3[p])
      );
    end else begin : g_none
      assign cull_s3[p] = 1'b0;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r      <= 1'b0;
      v_s2_r      <= 1'b0;
      v_s3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_s1_r      <= in_beat;
      v_s2_r      <= v_s1_r;
      v_s3_r      <= v_s2_r;
      out_valid_r <= v_s3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= !(|cull_s3);
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  `FBCT_ASSERT_IMPL(a_out_from_beat, clk, rst_n,
    out_valid, $past(start && !busy, 4))
  `FBCT_ASSERT_NEXT(a_visible_from_cull, clk, rst_n,
    v_s3_r, out_valid && (out_visible == !$past(|cull_s3)))
  `FBCT_ASSERT_NEXT(a_no_beat_no_out, clk, rst_n,
    !v_s3_r, !out_valid)

endmodule

/* test/frustum_box_cull_test_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_cull_test_checker
// Watches the box and plane ports of the cull block, keeps its own copy of
// the planes, works out the visible flag of every accepted box and compares
// it with the result beats in order.
// ----------------------------------------------------------------------------
module frustum_box_cull_test_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [15:0]                in_box_min_x,
  input  logic signed [15:0]                in_box_min_y,
  input  logic signed [15:0]                in_box_min_z,
  input  logic signed [15:0]                in_box_max_x,
  input  logic signed [15:0]                in_box_max_y,
  input  logic signed [15:0]                in_box_max_z,
  input  logic                              out_valid,
  input  logic                              out_visible,
  input  logic                              cfg_we,
  input  logic [fbct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbct_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                in_flight
);

  fbct_pkg::plane_t planes [fbct_pkg::NUM_REGS];
  logic             visible_due [$];

  // largest of n*a and n*b: the far corner along one axis
  function automatic longint axis_reach(logic signed [15:0] n, logic signed [15:0] a,
                                        logic signed [15:0] b);
    longint pa;
    longint pb;
    pa = longint'(n) * longint'(a);
    pb = longint'(n) * longint'(b);
    return (pa > pb) ? pa : pb;
  endfunction

  function automatic logic box_in_view();
    longint plane_d;
    for (int p = 0; p < fbct_pkg::NUM_REGS; p++) begin
      plane_d = axis_reach(planes[p].nx, in_box_min_x, in_box_max_x)
              + axis_reach(planes[p].ny, in_box_min_y, in_box_max_y)
              + axis_reach(planes[p].nz, in_box_min_z, in_box_max_z)
              + longint'(planes[p].off) * (64'sd1 <<< fbct_pkg::FRAC_W);
      if (plane_d < 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      foreach (planes[p])
        planes[p] = '0;
      visible_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (visible_due.size() == 0) begin
          $error("out_visible: expected none, got %0b", out_visible);
          fail_count = fail_count + 1;
        end else begin
          want = visible_due.pop_front();
          if (out_visible !== want) begin
            $error("out_visible: expected %0b, got %0b", want, out_visible);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_we && cfg_index < fbct_pkg::NUM_REGS)
        planes[cfg_index] = fbct_pkg::plane_t'(cfg_data);
      if (start && !busy)
        visible_due.push_back(box_in_view());
    end
    in_flight = visible_due.size();
  end

endmodule

/* test/frustum_box_cull_test_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_cull_test_tb
// Drives boxes and plane sets into the cull block: a directed pass over the
// reset planes, a hand-built frustum with touching and outside boxes, and
// extreme planes, then rounds of random planes with mostly near-frustum
// boxes. A checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module frustum_box_cull_test_tb;

  localparam int CW              = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_ROUNDS   = 8;
  localparam int BOXES_PER_ROUND = 112;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDX_W           = fbct_pkg::CFG_IDX_W;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;
  typedef enum int {
    PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM, PLANE_NEAR, PLANE_FAR
  } plane_slot_t;

  localparam coord_t Q_ONE = 16'sd16384;
  localparam coord_t C_MIN = 16'sh8000;
  localparam coord_t C_MAX = 16'sh7fff;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  coord_t                          in_box_min_x = '0;
  coord_t                          in_box_min_y = '0;
  coord_t                          in_box_min_z = '0;
  coord_t                          in_box_max_x = '0;
  coord_t                          in_box_max_y = '0;
  coord_t                          in_box_max_z = '0;
  logic                            out_valid;
  logic                            out_visible;
  logic                            cfg_we = 1'b0;
  logic [IDX_W-1:0]                cfg_index = '0;
  logic [fbct_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                              fail_count;
  int                              in_flight;
  int                              cycle_count = 0;
  bit                              calm = 1'b0;
  fbct_pkg::plane_t                frustum [fbct_pkg::NUM_REGS];

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("frustum_box_cull_test: mismatch");
      $finish;
    end
  end

  frustum_box_cull_test u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_min_z (in_box_min_z),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_box_max_z (in_box_max_z),
    .out_valid    (out_valid),
    .out_visible  (out_visible),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frustum_box_cull_test_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_min_z (in_box_min_z),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_box_max_z (in_box_max_z),
    .out_valid    (out_valid),
    .out_visible  (out_visible),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .in_flight    (in_flight)
  );

  // called at a falling edge; returns at the falling edge after the box is taken
  task automatic send_box(input box_t b);
    while (!calm && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_box_min_x <= b.min_x;
    in_box_min_y <= b.min_y;
    in_box_min_z <= b.min_z;
    in_box_max_x <= b.max_x;
    in_box_max_y <= b.max_y;
    in_box_max_z <= b.max_z;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (in_flight != 0)
      @(negedge clk);
  endtask

  // spare indices get random data, which must be dropped
  task automatic set_planes();
    for (int i = 0; i < 2**IDX_W; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= (i < fbct_pkg::NUM_REGS) ? 64'(frustum[i]) : {$urandom, $urandom};
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic fill_planes(input coord_t v);
    foreach (frustum[p])
      frustum[p] = '{off: v, nz: v, ny: v, nx: v};
  endtask

  function automatic coord_t edge_coord();
    case ($urandom_range(3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic fbct_pkg::plane_t rand_plane();
    fbct_pkg::plane_t p;
    case ($urandom_range(9))
      0: p = '0;
      1: p = fbct_pkg::plane_t'({$urandom, $urandom});
      2: p = '{off: edge_coord(), nz: edge_coord(), ny: edge_coord(), nx: edge_coord()};
      default: begin
        p.nx  = coord_t'(int'($urandom_range(32768)) - 16384);
        p.ny  = coord_t'(int'($urandom_range(32768)) - 16384);
        p.nz  = coord_t'(int'($urandom_range(32768)) - 16384);
        p.off = coord_t'(int'($urandom_range(4500)) - 500);
      end
    endcase
    return p;
  endfunction

  function automatic box_t rand_box();
    box_t   b;
    int     pick;
    int     cx, cy, cz, hx, hy, hz;
    coord_t t;
    pick = $urandom_range(99);
    if (pick < 8) begin
      b = box_t'({$urandom, $urandom, $urandom});
    end else if (pick < 12) begin
      b = '{edge_coord(), edge_coord(), edge_coord(),
            edge_coord(), edge_coord(), edge_coord()};
    end else begin
      cx = int'($urandom_range(4000)) - 2000;
      cy = int'($urandom_range(4000)) - 2000;
      cz = int'($urandom_range(4000)) - 2000;
      hx = $urandom_range(1500);
      hy = $urandom_range(1500);
      hz = $urandom_range(1500);
      b = '{coord_t'(cx - hx), coord_t'(cy - hy), coord_t'(cz - hz),
            coord_t'(cx + hx), coord_t'(cy + hy), coord_t'(cz + hz)};
      if (pick < 20) begin
        case ($urandom_range(2))
          0: begin t = b.min_x; b.min_x = b.max_x; b.max_x = t; end
          1: begin t = b.min_y; b.min_y = b.max_y; b.max_y = t; end
          default: begin t = b.min_z; b.min_z = b.max_z; b.max_z = t; end
        endcase
      end
    end
    return b;
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset planes are all zero and never cull
    send_box('{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX});
    send_box('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN});
    send_box('{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN});

    // x, y in [-1000, 1000], z in [0, 2000]
    drain();
    frustum[PLANE_LEFT]   = '{off: 16'sd1000, nz: '0, ny: '0, nx: Q_ONE};
    frustum[PLANE_RIGHT]  = '{off: 16'sd1000, nz: '0, ny: '0, nx: -Q_ONE};
    frustum[PLANE_TOP]    = '{off: 16'sd1000, nz: '0, ny: -Q_ONE, nx: '0};
    frustum[PLANE_BOTTOM] = '{off: 16'sd1000, nz: '0, ny: Q_ONE, nx: '0};
    frustum[PLANE_NEAR]   = '{off: '0, nz: Q_ONE, ny: '0, nx: '0};
    frustum[PLANE_FAR]    = '{off: 16'sd2000, nz: -Q_ONE, ny: '0, nx: '0};
    set_planes();
    send_box('{16'sd0, 16'sd0, 16'sd100, 16'sd10, 16'sd10, 16'sd200});
    send_box('{-16'sd3000, 16'sd0, 16'sd100, -16'sd1500, 16'sd10, 16'sd200});
    send_box('{-16'sd2000, 16'sd0, 16'sd100, -16'sd1000, 16'sd10, 16'sd200});
    send_box('{-16'sd2000, 16'sd0, 16'sd100, -16'sd1001, 16'sd10, 16'sd200});
    send_box('{16'sd1001, 16'sd0, 16'sd100, 16'sd3000, 16'sd10, 16'sd200});
    send_box('{16'sd0, 16'sd1200, 16'sd100, 16'sd10, 16'sd1300, 16'sd200});
    send_box('{16'sd0, -16'sd1300, 16'sd100, 16'sd10, -16'sd1200, 16'sd200});
    send_box('{16'sd0, 16'sd0, -16'sd100, 16'sd10, 16'sd10, -16'sd1});
    send_box('{16'sd0, 16'sd0, 16'sd2001, 16'sd10, 16'sd10, 16'sd2500});
    send_box('{16'sd500, 16'sd0, 16'sd100, -16'sd500, 16'sd10, 16'sd200});
    send_box('{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX});
    send_box('{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN});

    // extreme planes
    drain();
    fill_planes(C_MAX);
    set_planes();
    send_box('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN});
    send_box('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX});
    drain();
    fill_planes(C_MIN);
    set_planes();
    send_box('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX});
    send_box('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN});

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      drain();
      foreach (frustum[p])
        frustum[p] = rand_plane();
      set_planes();
      calm = (r == 2);
      repeat (BOXES_PER_ROUND)
        send_box(rand_box());
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && in_flight == 0)
      $display("frustum_box_cull_test: match");
    else
      $display("frustum_box_cull_test: mismatch");
    $finish;
  end

endmodule

/* frustum_box_cull_test.f */
+incdir+src
src/fbct_pkg.sv
src/fbct_axis_sort.sv
src/fbct_plane_eval.sv
src/frustum_box_cull_test.sv
test/frustum_box_cull_test_checker.sv
test/frustum_box_cull_test_tb.sv
